// File: sv/smpq_pkg.sv
package smpq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int VALUE_W         = 32;
	localparam int OCC_W           = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} stat_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] head_value;
		logic [1:0]                status;
		logic                      is_empty;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

// File: sv/smpq_ctrl.sv
module smpq_ctrl import smpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_EXEC);
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl.load  = 1'b0;
		ctl.exec  = 1'b0;
		busy      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec  = 1'b1;
				busy      = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign done = done_q;

	// A word is only ever reported in the cycle after the execute cycle.
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_EXEC)
		else $error("done without a preceding execute cycle");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_IDLE)
		else $error("execute state held for more than one cycle");

	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> ctl.exec && !done)
		else $error("accepted word not executed in the next cycle");

endmodule

// File: sv/smpq_datapath.sv
module smpq_datapath import smpq_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  cmd_t cmd,
	output rsp_t result
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0]                op_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]             count_q;
	logic signed [VALUE_W-1:0] entries_q [DEPTH];
	logic signed [VALUE_W-1:0] head_q;
	logic [1:0]                status_q;
	logic [DEPTH-1:0]          lt;
	logic                      full;
	logic                      empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= cmd.operation;
			val_q <= cmd.value;
		end
	end

	// Each cell compares its own entry with the new value; the stored order
	// makes lt a run of ones from position zero up to the insertion point.
	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			assign lt[i] = (CW'(i) < count_q) && (entries_q[i] < val_q);

			always_ff @(posedge clk) begin
				if (ctl.exec) begin
					if (op_q == OP_INSERT && !full && !lt[i]) begin
						if (i == 0) begin
							entries_q[i] <= val_q;
						end else if (lt[(i == 0) ? 0 : i-1]) begin
							entries_q[i] <= val_q;
						end else begin
							entries_q[i] <= entries_q[(i == 0) ? 0 : i-1];
						end
					end else if (op_q == OP_REMOVE && !empty && i < DEPTH-1) begin
						entries_q[i] <= entries_q[(i < DEPTH-1) ? i+1 : i];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			head_q   <= '0;
			status_q <= ST_OK;
		end else if (ctl.exec) begin
			head_q   <= '0;
			status_q <= ST_OK;
			case (op_q)
				OP_INSERT: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				OP_REMOVE: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						head_q  <= entries_q[0];
						count_q <= count_q - CW'(1);
					end
				end
				OP_PEEK: begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						head_q <= entries_q[0];
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign result.head_value = head_q;
	assign result.status     = status_q;
	assign result.is_empty   = empty;
	assign result.occupancy  = OCC_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above queue depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && op_q == OP_INSERT && full |=> status_q == ST_FULL && $stable(count_q))
		else $error("insert into a full queue changed the count");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && op_q == OP_REMOVE && !empty |=>
		count_q == CW'($past(count_q) - CW'(1)))
		else $error("remove did not drop exactly one entry");

	a_err_zero_head: assert property (@(posedge clk) disable iff (!arst_n)
		status_q != ST_OK |-> head_q == '0)
		else $error("error word carries a non-zero head value");

endmodule

// File: sv/sorted_min_priority_queue_core.sv
// Channel   Ports                     Handshake
// command   start, busy, cmd          taken at a rising edge with start high, busy low
// result    done, result              done high for one cycle; word taken at its end
//
// Each word is taken at the capture edge and then handled in the execute state, in which
// every entry cell compares with the new value in parallel and shifts or loads.
// done rises in the cycle after the execute cycle; busy is high only in the execute cycle.
// A new word may be started in the same cycle that done is shown.
// Reset clears the entry count; stored entries never reach a result until written.
// The receiver cannot stall, so results never wait.
module sorted_min_priority_queue_core import smpq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t result
);

	ctl_t ctl;

	smpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	smpq_datapath #(
		.DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.result (result)
	);

endmodule

// File: dv/tb_top.sv
module tb_top import smpq_pkg::*; ();

	localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WORDS_PER_PHASE = 230;
	localparam int CYCLE_LIMIT = 100000;
	localparam logic [VALUE_W-1:0] MOST_NEG = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] MOST_POS = 32'h7FFF_FFFF;

	typedef struct {
		logic [1:0]         op;
		logic [VALUE_W-1:0] value;
		bit                 fixed;
		rsp_t               want;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t result;

	rsp_t pending_rsp[$];
	logic signed [VALUE_W-1:0] model_vals [QUEUE_DEPTH];
	int model_count = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;
	int gap_pct = 15;
	int insert_pct = 50;

	// Expected words are typed in only for the empty, full and extreme rows.
	stim_row_t dir_rows [25] = '{
		'{OP_PEEK,   32'h0,         1'b1, '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
		'{OP_REMOVE, 32'h0,         1'b1, '{32'h0, ST_EMPTY, 1'b1, 5'd0}},
		'{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_OK, 1'b1, 5'd0}},
		'{OP_INSERT, 32'h0,         1'b0, '0},
		'{OP_INSERT, MOST_POS,      1'b0, '0},
		'{OP_INSERT, MOST_NEG,      1'b0, '0},
		'{OP_PEEK,   32'h0,         1'b1, '{MOST_NEG, ST_OK, 1'b0, 5'd3}},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'h0,         1'b0, '0},
		'{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'h1,         1'b0, '0},
		'{OP_INSERT, MOST_POS,      1'b0, '0},
		'{OP_INSERT, MOST_NEG,      1'b0, '0},
		'{OP_INSERT, 32'h5555_5555, 1'b0, '0},
		'{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
		'{OP_INSERT, 32'h0000_FFFF, 1'b0, '0},
		'{OP_INSERT, 32'hFFFF_0000, 1'b0, '0},
		'{OP_INSERT, 32'h1234_5678, 1'b0, '0},
		'{OP_INSERT, 32'h8000_0001, 1'b0, '0},
		'{OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
		'{OP_INSERT, 32'h0,         1'b1, '{32'h0, ST_FULL, 1'b0, 5'd16}},
		'{OP_PEEK,   32'h0,         1'b1, '{MOST_NEG, ST_OK, 1'b0, 5'd16}},
		'{OP_UNUSED, 32'h0,         1'b1, '{32'h0, ST_OK, 1'b0, 5'd16}},
		'{OP_REMOVE, 32'h0,         1'b1, '{MOST_NEG, ST_OK, 1'b0, 5'd15}},
		'{OP_REMOVE, 32'h0,         1'b1, '{MOST_NEG, ST_OK, 1'b0, 5'd14}}
	};

	sorted_min_priority_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one word to the local copy of the queue and returns its response.
	function automatic rsp_t next_queue_response(input cmd_t c);
		rsp_t r;
		int pos;
		r = '0;
		r.status = ST_OK;
		case (c.operation)
		OP_INSERT: begin
			if (model_count >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// A new value goes in front of any equal stored value.
				pos = 0;
				while (pos < model_count && model_vals[pos] < $signed(c.value))
					pos++;
				for (int i = model_count; i > pos; i--)
					model_vals[i] = model_vals[i-1];
				model_vals[pos] = c.value;
				model_count++;
			end
		end
		OP_REMOVE: begin
			if (model_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.head_value = model_vals[0];
				for (int i = 1; i < model_count; i++)
					model_vals[i-1] = model_vals[i];
				model_count--;
			end
		end
		OP_PEEK: begin
			if (model_count == 0)
				r.status = ST_EMPTY;
			else
				r.head_value = model_vals[0];
		end
		default: ;
		endcase
		r.is_empty = (model_count == 0);
		r.occupancy = OCC_W'(model_count);
		return r;
	endfunction

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return OP_UNUSED;
		if ($urandom_range(99) < insert_pct)
			return OP_INSERT;
		return ($urandom_range(9) < 6) ? OP_REMOVE : OP_PEEK;
	endfunction

	// Small values and copies of stored ones give plenty of equal keys.
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return $urandom;
		if (r < 7)
			return VALUE_W'($signed($urandom_range(20)) - 10);
		if (r == 7) begin
			case ($urandom_range(3))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return '0;
			default: return '1;
			endcase
		end
		if (r == 8 && model_count > 0)
			return model_vals[$urandom_range(model_count - 1)];
		return $urandom;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		mismatch_cnt++;
	endtask

	task automatic issue_word(input logic [1:0] op, input logic [VALUE_W-1:0] val,
			input bit fixed, input rsp_t want, input bit pause_after);
		cmd_t c;
		rsp_t pred;
		c.operation = op;
		c.value = val;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		pred = next_queue_response(c);
		pending_rsp.push_back(fixed ? want : pred);
		if (pause_after) begin
			start <= 1'b0;
			do @(posedge clk); while (pending_rsp.size() != 0);
		end else if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : result_check
		rsp_t want;
		if (done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result word", result.head_value, '0);
			end else begin
				want = pending_rsp.pop_front();
				if (result.head_value !== want.head_value)
					report_mismatch("head_value", result.head_value, want.head_value);
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.is_empty !== want.is_empty)
					report_mismatch("is_empty", result.is_empty, want.is_empty);
				if (result.occupancy !== want.occupancy)
					report_mismatch("occupancy", result.occupancy, want.occupancy);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sorted_min_priority_queue_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			issue_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].fixed,
				dir_rows[i].want, i == $size(dir_rows) - 1);
		// Three phases: light sender gaps, heavy gaps, then back to back.
		for (int ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 15 : (ph == 1) ? 52 : 0;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// Shift the insert bias now and then so the queue both fills and drains.
				if (n % 40 == 0)
					insert_pct = $urandom_range(15, 85);
				issue_word(pick_op(), pick_value(), 1'b0, '0, n == WORDS_PER_PHASE - 1);
			end
		end
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_rsp.size() == 0)
			$display("sorted_min_priority_queue_core test passed");
		else
			$display("sorted_min_priority_queue_core test failed");
		$finish;
	end

endmodule
